[design/ubxfp_pkg.sv]
// Shared types and constants of the UBX frame parser.
package ubxfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	localparam int unsigned ADDR_W = 4;

	localparam logic [1:0] REG_CLASS  = 2'd0;
	localparam logic [1:0] REG_ID     = 2'd1;
	localparam logic [1:0] REG_LENGTH = 2'd2;

	localparam logic [7:0]  RST_CLASS  = 8'd1;
	localparam logic [7:0]  RST_ID     = 8'd7;
	localparam logic [15:0] RST_LENGTH = 16'd92;

	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_SYNC1   = 9'b000000010,
		PH_SYNC2   = 9'b000000100,
		PH_CLASS   = 9'b000001000,
		PH_ID      = 9'b000010000,
		PH_LENLO   = 9'b000100000,
		PH_PAYLOAD = 9'b001000000,
		PH_CKA     = 9'b010000000,
		PH_CKB     = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [7:0]  message_class;
		logic [7:0]  message_id;
		logic [15:0] payload_length;
	} cfg_t;

endpackage

[design/ubxfp_in_if.sv]
// Byte channel into the UBX frame parser.
interface ubxfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[design/ubxfp_out_if.sv]
// Result channel out of the UBX frame parser.
interface ubxfp_out_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [15:0] payload_index;
	logic [7:0]  payload_byte;
	logic        frame_done;
	logic        frame_good;

	modport source (
		output valid, output payload_valid, output payload_index, output payload_byte,
		output frame_done, output frame_good, input ready
	);
	modport sink (
		input valid, input payload_valid, input payload_index, input payload_byte,
		input frame_done, input frame_good, output ready
	);
endinterface

[design/ubxfp_apb_regs.sv]
// APB configuration registers of the UBX frame parser.
module ubxfp_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ubxfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output ubxfp_pkg::cfg_t              cfg
);

	ubxfp_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic [1:0]      reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.message_class  <= ubxfp_pkg::RST_CLASS;
			cfg_q.message_id     <= ubxfp_pkg::RST_ID;
			cfg_q.payload_length <= ubxfp_pkg::RST_LENGTH;
		end else if (wr_en) begin
			case (reg_idx)
				ubxfp_pkg::REG_CLASS:  cfg_q.message_class  <= pwdata[7:0];
				ubxfp_pkg::REG_ID:     cfg_q.message_id     <= pwdata[7:0];
				ubxfp_pkg::REG_LENGTH: cfg_q.payload_length <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ubxfp_pkg::REG_CLASS:  prdata = {24'd0, cfg_q.message_class};
			ubxfp_pkg::REG_ID:     prdata = {24'd0, cfg_q.message_id};
			ubxfp_pkg::REG_LENGTH: prdata = {16'd0, cfg_q.payload_length};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

[design/ubx_frame_parser_core.sv]
// Top level of the UBX frame parser: input stage, frame state machine and result register.
// The parser takes one received byte per clock while results are not held up, and returns exactly
// one result item per byte, which passes through the input stage and the result register. The
// frame state, the byte count and the 8-bit Fletcher sums update together from the registered
// byte, so while the result side is free a new byte can be accepted on every clock; the result
// register takes the next item at the same edge at which a waiting result leaves, and input ready
// falls only when both the input stage and the result register hold items that cannot move on.
// The user must write the configuration registers over APB only while idle; the block does not enforce it.
module ubx_frame_parser_core (
	input  logic                         clk,
	input  logic                         arst_n,
	ubxfp_in_if.sink                     rx,
	ubxfp_out_if.source                  res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ubxfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	ubxfp_pkg::cfg_t cfg;

	ubxfp_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic        vld_s2;
	logic        pvalid_s2;
	logic [15:0] pindex_s2;
	logic [7:0]  pbyte_s2;
	logic        done_s2;
	logic        good_s2;

	ubxfp_pkg::phase_t phase_q, phase_d;
	logic [7:0]        len_lo_q, len_lo_d;
	logic [15:0]       pos_q, pos_d;
	logic [7:0]        ck_a_q, ck_a_d;
	logic [7:0]        sum_a_q, sum_a_d;
	logic [7:0]        sum_b_q, sum_b_d;

	logic [7:0]  add_a;
	logic [7:0]  add_b;
	logic [16:0] pos_next;
	logic [15:0] declared;

	logic        pvalid_d;
	logic [15:0] pindex_d;
	logic [7:0]  pbyte_d;
	logic        done_d;
	logic        good_d;

	assign advance  = vld_s1 && (!vld_s2 || res.ready);
	assign rx.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign add_a    = sum_a_q + byte_s1;
	assign add_b    = sum_b_q + add_a;
	assign pos_next = {1'b0, pos_q} + 17'd1;
	assign declared = {byte_s1, len_lo_q};

	always_comb begin
		phase_d  = phase_q;
		len_lo_d = len_lo_q;
		pos_d    = pos_q;
		ck_a_d   = ck_a_q;
		sum_a_d  = sum_a_q;
		sum_b_d  = sum_b_q;
		pvalid_d = 1'b0;
		pindex_d = 16'd0;
		pbyte_d  = 8'd0;
		done_d   = 1'b0;
		good_d   = 1'b0;
		case (phase_q)
			ubxfp_pkg::PH_SYNC1: begin
				if (byte_s1 == ubxfp_pkg::SYNC_SECOND) begin
					phase_d = ubxfp_pkg::PH_SYNC2;
					sum_a_d = 8'd0;
					sum_b_d = 8'd0;
				end else if (byte_s1 != ubxfp_pkg::SYNC_FIRST) begin
					phase_d = ubxfp_pkg::PH_IDLE;
				end
			end
			ubxfp_pkg::PH_SYNC2: begin
				if (byte_s1 == cfg.message_class) begin
					sum_a_d = add_a;
					sum_b_d = add_b;
					phase_d = ubxfp_pkg::PH_CLASS;
				end else begin
					phase_d = ubxfp_pkg::PH_IDLE;
				end
			end
			ubxfp_pkg::PH_CLASS: begin
				if (byte_s1 == cfg.message_id) begin
					sum_a_d = add_a;
					sum_b_d = add_b;
					phase_d = ubxfp_pkg::PH_ID;
				end else begin
					phase_d = ubxfp_pkg::PH_IDLE;
				end
			end
			ubxfp_pkg::PH_ID: begin
				len_lo_d = byte_s1;
				sum_a_d  = add_a;
				sum_b_d  = add_b;
				phase_d  = ubxfp_pkg::PH_LENLO;
			end
			ubxfp_pkg::PH_LENLO: begin
				sum_a_d = add_a;
				sum_b_d = add_b;
				if (declared != cfg.payload_length) begin
					phase_d = ubxfp_pkg::PH_IDLE;
				end else begin
					pos_d   = 16'd0;
					phase_d = (declared == 16'd0) ? ubxfp_pkg::PH_CKA : ubxfp_pkg::PH_PAYLOAD;
				end
			end
			ubxfp_pkg::PH_PAYLOAD: begin
				pvalid_d = 1'b1;
				pindex_d = pos_q;
				pbyte_d  = byte_s1;
				sum_a_d  = add_a;
				sum_b_d  = add_b;
				pos_d    = pos_next[15:0];
				if (pos_next >= {1'b0, cfg.payload_length}) begin
					phase_d = ubxfp_pkg::PH_CKA;
				end
			end
			ubxfp_pkg::PH_CKA: begin
				ck_a_d  = byte_s1;
				phase_d = ubxfp_pkg::PH_CKB;
			end
			ubxfp_pkg::PH_CKB: begin
				done_d  = 1'b1;
				good_d  = (ck_a_q == sum_a_q) && (byte_s1 == sum_b_q);
				phase_d = ubxfp_pkg::PH_IDLE;
			end
			default: begin
				phase_d = (byte_s1 == ubxfp_pkg::SYNC_FIRST) ? ubxfp_pkg::PH_SYNC1
					: ubxfp_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ubxfp_pkg::PH_IDLE;
			len_lo_q <= 8'd0;
			pos_q    <= 16'd0;
			ck_a_q   <= 8'd0;
			sum_a_q  <= 8'd0;
			sum_b_q  <= 8'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			len_lo_q <= len_lo_d;
			pos_q    <= pos_d;
			ck_a_q   <= ck_a_d;
			sum_a_q  <= sum_a_d;
			sum_b_q  <= sum_b_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (res.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pvalid_s2 <= pvalid_d;
			pindex_s2 <= pindex_d;
			pbyte_s2  <= pbyte_d;
			done_s2   <= done_d;
			good_s2   <= good_d;
		end
	end

	assign res.valid         = vld_s2;
	assign res.payload_valid = pvalid_s2;
	assign res.payload_index = pindex_s2;
	assign res.payload_byte  = pbyte_s2;
	assign res.frame_done    = done_s2;
	assign res.frame_good    = good_s2;

endmodule

[bench/ubxfp_frame_checker.sv]
// Checker that predicts every result item of the UBX frame parser and compares it with the block.
module ubxfp_frame_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	ubxfp_in_if                          rx,
	ubxfp_out_if                         res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ubxfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic [31:0]                  prdata,
	input  logic                         pready,
	output int                           mismatches,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import ubxfp_pkg::*;

	typedef struct packed {
		logic        payload_valid;
		logic [15:0] payload_index;
		logic [7:0]  payload_byte;
		logic        frame_done;
		logic        frame_good;
	} parse_result_t;

	cfg_t          cfg;
	phase_t        phase;
	logic [7:0]    len_low;
	logic [15:0]   position;
	logic [7:0]    check_a;
	logic [7:0]    sum_a;
	logic [7:0]    sum_b;
	parse_result_t pending_results[$];
	parse_result_t got;
	parse_result_t want;
	logic [31:0]   reg_value;
	int            fail_count;

	assign mismatches = fail_count;

	function automatic void fold_sum(input logic [7:0] b);
		sum_a = sum_a + b;
		sum_b = sum_b + sum_a;
	endfunction

	function automatic parse_result_t parse_byte(input logic [7:0] b);
		parse_result_t r;
		logic [16:0]   next_pos;
		logic [15:0]   declared;
		r = '0;
		case (phase)
			PH_SYNC1: begin
				if (b == SYNC_SECOND) begin
					phase = PH_SYNC2;
					sum_a = '0;
					sum_b = '0;
				end else if (b != SYNC_FIRST) begin
					phase = PH_IDLE;
				end
			end
			PH_SYNC2: begin
				if (b == cfg.message_class) begin
					fold_sum(b);
					phase = PH_CLASS;
				end else begin
					phase = PH_IDLE;
				end
			end
			PH_CLASS: begin
				if (b == cfg.message_id) begin
					fold_sum(b);
					phase = PH_ID;
				end else begin
					phase = PH_IDLE;
				end
			end
			PH_ID: begin
				len_low = b;
				fold_sum(b);
				phase = PH_LENLO;
			end
			PH_LENLO: begin
				declared = {b, len_low};
				fold_sum(b);
				if (declared != cfg.payload_length) begin
					phase = PH_IDLE;
				end else begin
					position = '0;
					phase = (declared == 16'd0) ? PH_CKA : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				next_pos = {1'b0, position} + 17'd1;
				r.payload_valid = 1'b1;
				r.payload_index = position;
				r.payload_byte = b;
				fold_sum(b);
				if (next_pos >= {1'b0, cfg.payload_length})
					phase = PH_CKA;
				position = next_pos[15:0];
			end
			PH_CKA: begin
				check_a = b;
				phase = PH_CKB;
			end
			PH_CKB: begin
				r.frame_done = 1'b1;
				r.frame_good = (check_a == sum_a) && (b == sum_b);
				phase = PH_IDLE;
			end
			default: begin
				phase = (b == SYNC_FIRST) ? PH_SYNC1 : PH_IDLE;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{message_class: RST_CLASS, message_id: RST_ID, payload_length: RST_LENGTH};
			phase = PH_IDLE;
			len_low = '0;
			position = '0;
			check_a = '0;
			sum_a = '0;
			sum_b = '0;
			pending_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (res.valid && res.ready) begin
				got = {res.payload_valid, res.payload_index, res.payload_byte,
					res.frame_done, res.frame_good};
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result item: valid=%0b idx=%0d byte=%02h done=%0b good=%0b",
							got.payload_valid, got.payload_index, got.payload_byte,
							got.frame_done, got.frame_good);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"result mismatch: expected valid=%0b idx=%0d byte=%02h ",
								"done=%0b good=%0b, got valid=%0b idx=%0d byte=%02h done=%0b good=%0b"},
								want.payload_valid, want.payload_index, want.payload_byte,
								want.frame_done, want.frame_good,
								got.payload_valid, got.payload_index, got.payload_byte,
								got.frame_done, got.frame_good);
					end
				end
			end
			if (rx.valid && rx.ready)
				pending_results.push_back(parse_byte(rx.rx_byte));
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_CLASS:  cfg.message_class = pwdata[7:0];
						REG_ID:     cfg.message_id = pwdata[7:0];
						REG_LENGTH: cfg.payload_length = pwdata[15:0];
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						REG_CLASS:  reg_value = {24'd0, cfg.message_class};
						REG_ID:     reg_value = {24'd0, cfg.message_id};
						REG_LENGTH: reg_value = {16'd0, cfg.payload_length};
						default:    reg_value = prdata;
					endcase
					if (prdata !== reg_value) begin
						fail_count++;
						if (fail_count <= 10)
							$display("register read mismatch at %0h: expected %08h, got %08h",
								paddr, reg_value, prdata);
					end
				end
			end
			pending <= pending_results.size();
		end
	end

endmodule

[bench/tb_ubx_frame_parser_core.sv]
// Testbench top of the UBX frame parser: clock, reset, register writes, byte stimulus and verdict.
module tb_ubx_frame_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ubxfp_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	int                  mismatches;
	int                  pending;

	cfg_t                cur_cfg;
	bit                  src_steady;
	bit                  sink_steady;
	int                  stall_left;
	int                  bytes_sent;
	int                  random_start;
	int                  phase_start;
	int                  pick;
	logic [7:0]          hand_a;
	logic [7:0]          hand_b;
	logic [15:0]         bad_len;

	ubxfp_in_if  rx_ch ();
	ubxfp_out_if res_ch ();

	ubx_frame_parser_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ubxfp_frame_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.res        (res_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			res_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			res_ch.ready <= 1'b1;
			if (!sink_steady && $urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_summed(input logic [7:0] b, inout logic [7:0] sa, inout logic [7:0] sb);
		sa = sa + b;
		sb = sb + sa;
		send_byte(b);
	endtask

	task automatic send_frame(input logic [7:0] cls, input logic [7:0] mid,
		input logic [15:0] declared, input int count, input bit bad_sum,
		input bit extra_sync, input bit sync_payload);
		logic [7:0] sa;
		logic [7:0] sb;
		sa = '0;
		sb = '0;
		send_byte(SYNC_FIRST);
		if (extra_sync)
			send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_summed(cls, sa, sb);
		send_summed(mid, sa, sb);
		send_summed(declared[7:0], sa, sb);
		send_summed(declared[15:8], sa, sb);
		for (int i = 0; i < count; i++)
			send_summed(sync_payload ? ((i % 2 == 0) ? SYNC_FIRST : SYNC_SECOND) : 8'($urandom),
				sa, sb);
		if (bad_sum) begin
			if ($urandom_range(0, 1) == 0)
				sa = sa ^ (8'd1 << $urandom_range(0, 7));
			else
				sb = sb ^ (8'd1 << $urandom_range(0, 7));
		end
		send_byte(sa);
		send_byte(sb);
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input bit is_write, input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= {idx, 2'b00};
		pwdata <= is_write ? value : 32'd0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (is_write) begin
			case (idx)
				REG_CLASS:  cur_cfg.message_class = value[7:0];
				REG_ID:     cur_cfg.message_id = value[7:0];
				REG_LENGTH: cur_cfg.payload_length = value[15:0];
				default: ;
			endcase
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		cur_cfg = '{message_class: RST_CLASS, message_id: RST_ID, payload_length: RST_LENGTH};
		src_steady = 1'b0;
		sink_steady = 1'b0;
		bytes_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_access(1'b0, REG_CLASS, 32'd0);
		apb_access(1'b0, REG_ID, 32'd0);
		apb_access(1'b0, REG_LENGTH, 32'd0);

		apb_access(1'b1, REG_LENGTH, 32'd2);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(cur_cfg.message_class, cur_cfg.message_id, 16'd2, 2, 1'b0, 1'b1, 1'b1);
		settle();

		apb_access(1'b1, REG_CLASS, 32'h00);
		apb_access(1'b1, REG_ID, 32'hFF);
		apb_access(1'b1, REG_LENGTH, 32'd0);
		send_frame(8'h00, 8'hFF, 16'd0, 0, 1'b1, 1'b0, 1'b0);
		settle();

		// A long frame is cut short by lowering the length register in the middle of its
		// payload; the class register is also changed after the class byte was accepted.
		apb_access(1'b1, REG_CLASS, 32'hFF);
		apb_access(1'b1, REG_ID, 32'h00);
		apb_access(1'b1, REG_LENGTH, 32'hFFFF);
		apb_access(1'b0, REG_LENGTH, 32'd0);
		hand_a = '0;
		hand_b = '0;
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_summed(8'hFF, hand_a, hand_b);
		settle();
		apb_access(1'b1, REG_CLASS, 32'h3C);
		send_summed(8'h00, hand_a, hand_b);
		send_summed(8'hFF, hand_a, hand_b);
		send_summed(8'hFF, hand_a, hand_b);
		repeat (2) send_summed(8'($urandom), hand_a, hand_b);
		settle();
		apb_access(1'b1, REG_LENGTH, 32'd1);
		send_summed(8'($urandom), hand_a, hand_b);
		send_byte(hand_a);
		send_byte(hand_b);
		settle();

		random_start = bytes_sent;
		while (bytes_sent - random_start < 400) begin
			settle();
			apb_access(1'b1, REG_CLASS, $urandom_range(0, 255));
			apb_access(1'b1, REG_ID, $urandom_range(0, 255));
			pick = $urandom_range(0, 99);
			if (pick < 70)
				apb_access(1'b1, REG_LENGTH, $urandom_range(1, 6));
			else if (pick < 90)
				apb_access(1'b1, REG_LENGTH, $urandom_range(7, 24));
			else
				apb_access(1'b1, REG_LENGTH, $urandom_range(25, 64));
			src_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < 60 && bytes_sent - random_start < 400) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					send_frame(cur_cfg.message_class, cur_cfg.message_id, cur_cfg.payload_length,
						cur_cfg.payload_length, $urandom_range(0, 7) == 0,
						$urandom_range(0, 5) == 0, 1'b0);
				end else if (pick < 72) begin
					send_frame(cur_cfg.message_class ^ 8'($urandom_range(1, 255)),
						cur_cfg.message_id, cur_cfg.payload_length, $urandom_range(0, 4),
						1'b0, 1'b0, 1'b0);
				end else if (pick < 79) begin
					send_frame(cur_cfg.message_class,
						cur_cfg.message_id ^ 8'($urandom_range(1, 255)),
						cur_cfg.payload_length, $urandom_range(0, 4), 1'b0, 1'b0, 1'b0);
				end else if (pick < 86) begin
					bad_len = cur_cfg.payload_length ^ 16'($urandom_range(1, 65535));
					send_frame(cur_cfg.message_class, cur_cfg.message_id, bad_len,
						$urandom_range(0, 4), 1'b0, 1'b0, 1'b0);
				end else if (pick < 92) begin
					send_frame(cur_cfg.message_class, cur_cfg.message_id, cur_cfg.payload_length,
						$urandom_range(0, cur_cfg.payload_length - 1), 1'b0, 1'b0, 1'b0);
				end else begin
					repeat ($urandom_range(1, 4))
						send_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
				end
			end
		end
		settle();

		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
